// ===== rtl/swps_pkg.sv =====
// swps_pkg: shared constants of the shallow water pipe step block
// action codes, register indexes, reset values and fixed-point limits
// no dependencies
package swps_pkg;

  localparam int MAX_COLUMNS_DEF   = 64;
  localparam int MAX_ROWS_DEF      = 64;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [2:0] ACT_TERRAIN = 3'd0;
  localparam logic [2:0] ACT_ADD     = 3'd1;
  localparam logic [2:0] ACT_REMOVE  = 3'd2;
  localparam logic [2:0] ACT_STEP    = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;
  localparam logic [2:0] ACT_VOLUME  = 3'd5;

  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_CELL    = 3'd2;
  localparam logic [2:0] REG_GRAVITY = 3'd3;
  localparam logic [2:0] REG_SUBDT   = 3'd4;
  localparam logic [2:0] REG_DAMPING = 3'd5;

  localparam logic [6:0]  WIDTH_RST   = 7'd64;
  localparam logic [6:0]  HEIGHT_RST  = 7'd64;
  localparam logic [30:0] CELL_RST    = 31'd65536;
  localparam logic [30:0] GRAVITY_RST = 31'd642908;
  localparam logic [30:0] SUBDT_RST   = 31'd1049;
  localparam logic [30:0] DAMPING_RST = 31'd0;

  localparam logic [63:0] LIM63      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM62      = 64'h4000_0000_0000_0000;
  localparam logic [30:0] VAL_MAX    = 31'h7FFF_FFFF;
  localparam logic [63:0] EXP_M1_Q30 = 64'd395007542;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;

endpackage

// ===== rtl/shallow_water_pipe_step.sv =====
// shallow_water_pipe_step: virtual pipe height-field water grid, Q fixed point
// after reset a clearing pass over all MAX_COLUMNS*MAX_ROWS cells zeroes all stores, busy high
// one shared 64x64 multiplier and one radix-2 divider under a sequencer
// read/terrain write/add/remove touch one cell; volume sums over every cell in use
// step: n substeps, each a flux pass, a damping pass when damping is set, and a depth pass
// results are strobed on done_o for one cycle; the receiver cannot stall
module shallow_water_pipe_step #(
  parameter int MAX_COLUMNS   = swps_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = swps_pkg::MAX_ROWS_DEF,
  parameter int FRACTION_BITS = swps_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         action_i,
  input  logic [5:0]         cell_x_i,
  input  logic [5:0]         cell_y_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [30:0]        cfg_wdata_i,
  output logic               done_o,
  output logic               status_o,
  output logic [30:0]        water_depth_o,
  output logic signed [31:0] terrain_height_o,
  output logic [30:0]        flux_left_o,
  output logic [30:0]        flux_right_o,
  output logic [30:0]        flux_top_o,
  output logic [30:0]        flux_bottom_o,
  output logic [62:0]        total_volume_o,
  output logic [15:0]        substeps_run_o
);

  localparam int F      = FRACTION_BITS;
  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int AREA_W = 62 - F;
  localparam int TINY   = (1 << F) / 1000000;

  localparam logic [5:0] S_CLEAR   = 6'd0;
  localparam logic [5:0] S_IDLE    = 6'd1;
  localparam logic [5:0] S_AREA    = 6'd2;
  localparam logic [5:0] S_RD      = 6'd3;
  localparam logic [5:0] S_ADDDIV  = 6'd4;
  localparam logic [5:0] S_NDIV    = 6'd5;
  localparam logic [5:0] S_SUBDIV  = 6'd6;
  localparam logic [5:0] S_XMUL    = 6'd7;
  localparam logic [5:0] S_TAYMUL  = 6'd8;
  localparam logic [5:0] S_TAYDIV  = 6'd9;
  localparam logic [5:0] S_EXPCHK  = 6'd10;
  localparam logic [5:0] S_EXPMUL  = 6'd11;
  localparam logic [5:0] S_CSTART  = 6'd12;
  localparam logic [5:0] S_CMUL    = 6'd13;
  localparam logic [5:0] S_CDIV    = 6'd14;
  localparam logic [5:0] S_P1_RD   = 6'd15;
  localparam logic [5:0] S_P1_OWN  = 6'd16;
  localparam logic [5:0] S_P1_NB   = 6'd17;
  localparam logic [5:0] S_P1_DIFF = 6'd18;
  localparam logic [5:0] S_P1_PIPE = 6'd19;
  localparam logic [5:0] S_P1_SUM  = 6'd20;
  localparam logic [5:0] S_P1_AMUL = 6'd21;
  localparam logic [5:0] S_P1_ALW  = 6'd22;
  localparam logic [5:0] S_P1_LMUL = 6'd23;
  localparam logic [5:0] S_P1_LDIV = 6'd24;
  localparam logic [5:0] S_P1_WR   = 6'd25;
  localparam logic [5:0] S_P2_RD   = 6'd26;
  localparam logic [5:0] S_P2_OWN  = 6'd27;
  localparam logic [5:0] S_P2_MUL  = 6'd28;
  localparam logic [5:0] S_P2_WR   = 6'd29;
  localparam logic [5:0] S_P3_RD   = 6'd30;
  localparam logic [5:0] S_P3_OWN  = 6'd31;
  localparam logic [5:0] S_P3_NB   = 6'd32;
  localparam logic [5:0] S_P3_ACC  = 6'd33;
  localparam logic [5:0] S_P3_CALC = 6'd34;
  localparam logic [5:0] S_P3_MUL  = 6'd35;
  localparam logic [5:0] S_P3_DIV  = 6'd36;
  localparam logic [5:0] S_VOL_RD  = 6'd37;
  localparam logic [5:0] S_VOL_GO  = 6'd38;
  localparam logic [5:0] S_VOL_ACC = 6'd39;
  localparam logic [5:0] S_MUL     = 6'd40;
  localparam logic [5:0] S_DIV     = 6'd41;

  // memories
  logic [31:0]       terr_mem [CELLS];
  logic [30:0]       dep_mem  [CELLS];
  logic [3:0][30:0]  flx_mem  [CELLS];

  logic [AW-1:0]     rd_addr, wr_addr;
  logic              we_terr, we_dep, we_flx;
  logic [31:0]       wd_terr;
  logic [30:0]       wd_dep;
  logic [3:0][30:0]  wd_flx;
  logic [31:0]       rd_terr_q;
  logic [30:0]       rd_dep_q;
  logic [3:0][30:0]  rd_flx_q;

  always_ff @(posedge clk_i) begin
    if (we_terr) terr_mem[wr_addr] <= wd_terr;
    if (we_dep)  dep_mem[wr_addr]  <= wd_dep;
    if (we_flx)  flx_mem[wr_addr]  <= wd_flx;
    rd_terr_q <= terr_mem[rd_addr];
    rd_dep_q  <= dep_mem[rd_addr];
    rd_flx_q  <= flx_mem[rd_addr];
  end

  // control registers
  logic [5:0]    state_q, state_d, ret_q, ret_d;
  logic          done_q, done_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [6:0]    gw_q, gh_q;
  logic [30:0]   csz_q, grav_q, msd_q, damp_q;

  // datapath registers
  logic [2:0]         act_q, act_d;
  logic [31:0]        val_q, val_d;
  logic [6:0]         cx_q, cx_d, cy_q, cy_d;
  logic [1:0]         dir_q, dir_d;
  logic [AREA_W-1:0]  area_q, area_d;
  logic [15:0]        n_q, n_d, sub_q, sub_d;
  logic [30:0]        subdt_q, subdt_d;
  logic [63:0]        c_q, c_d;
  logic [F:0]         factor_q, factor_d;
  logic [29:0]        r_q, r_d;
  logic [30:0]        term_q, term_d;
  logic signed [33:0] sum_q, sum_d;
  logic [3:0]         k_q, k_d;
  logic [4:0]         ecnt_q, ecnt_d;
  logic [30:0]        v_q, v_d;
  logic signed [33:0] e_q, e_d;
  logic [30:0]        d_q, d_d;
  logic [3:0][30:0]   f_q, f_d;
  logic [32:0]        s_q, s_d;
  logic [62:0]        allowed_q, allowed_d;
  logic               neg_q, neg_d;
  logic [32:0]        in_q, in_d, out_q, out_d;
  logic [62:0]        acc_q, acc_d;
  logic [63:0]        ma_q, ma_d, mb_q, mb_d;
  logic [127:0]       prod_q, prod_d;
  logic [1:0]         mcnt_q, mcnt_d;
  logic [63:0]        dq_q, dq_d, dd_q, dd_d;
  logic [64:0]        dr_q, dr_d;
  logic [5:0]         dcnt_q, dcnt_d;

  logic               status_q, status_d;
  logic [30:0]        wdep_q, wdep_d;
  logic [31:0]        terr_q, terr_d;
  logic [3:0][30:0]   fo_q, fo_d;
  logic [62:0]        vol_q, vol_d;
  logic [15:0]        nrun_q, nrun_d;

  // comb helpers
  logic [6:0]         cols, rows;
  logic [AW-1:0]      cidx;
  logic               bad, last_cell, nb_ok;
  logic [6:0]         nx, ny;
  logic               mul_go, div_go;
  logic [63:0]        mul_a, mul_b, div_n, div_m;
  logic [5:0]         go_ret;
  logic [63:0]        sat63, sat62, vabs, t64, q64, msd64, dx64, x64, nint;
  logic signed [33:0] nb_elev;
  logic signed [34:0] diff;
  logic [34:0]        mag;
  logic [63:0]        pp;
  logic [127:0]       pp_ext;
  logic [64:0]        trial;
  logic [63:0]        nd_u;
  logic signed [34:0] nd_s;
  logic [32:0]        delta;
  logic signed [33:0] sum_new;
  logic [62:0]        acc_new;
  logic [63:0]        p63;

  always_comb begin
    if (gw_q == 7'd0) cols = 7'd1;
    else if (32'(gw_q) > MAX_COLUMNS) cols = 7'(MAX_COLUMNS);
    else cols = gw_q;
    if (gh_q == 7'd0) rows = 7'd1;
    else if (32'(gh_q) > MAX_ROWS) rows = 7'(MAX_ROWS);
    else rows = gh_q;
  end

  assign cidx = AW'(cy_q) * AW'(MAX_COLUMNS) + AW'(cx_q);
  assign bad  = (cx_q >= cols) || (cy_q >= rows);
  assign last_cell = (cx_q + 7'd1 == cols) && (cy_q + 7'd1 == rows);
  assign nx = (cx_q + 7'd1 == cols) ? 7'd0 : cx_q + 7'd1;
  assign ny = (cx_q + 7'd1 == cols) ? cy_q + 7'd1 : cy_q;

  always_comb begin
    unique case (dir_q)
      2'd0: nb_ok = cx_q != 7'd0;
      2'd1: nb_ok = cx_q + 7'd1 < cols;
      2'd2: nb_ok = cy_q != 7'd0;
      default: nb_ok = cy_q + 7'd1 < rows;
    endcase
  end

  always_comb begin
    rd_addr = cidx;
    if (state_q == S_P1_NB || state_q == S_P3_NB) begin
      unique case (dir_q)
        2'd0: rd_addr = cidx - AW'(1);
        2'd1: rd_addr = cidx + AW'(1);
        2'd2: rd_addr = cidx - AW'(MAX_COLUMNS);
        default: rd_addr = cidx + AW'(MAX_COLUMNS);
      endcase
    end
  end

  assign wr_addr = (state_q == S_CLEAR) ? clr_q : cidx;
  assign msd64   = (msd_q == 31'd0) ? 64'd1 : {33'd0, msd_q};
  assign dx64    = (csz_q == 31'd0) ? 64'd1 : {33'd0, csz_q};
  assign sat63   = (prod_q[127:63] != 65'd0) ? swps_pkg::LIM63 : prod_q[63:0];
  assign sat62   = (prod_q > {64'd0, swps_pkg::LIM62}) ? swps_pkg::LIM62 : prod_q[63:0];
  assign vabs    = val_q[31] ? (64'd0 - {{32{val_q[31]}}, val_q}) : {32'd0, val_q};
  assign nb_elev = $signed({{2{rd_terr_q[31]}}, rd_terr_q}) + $signed({3'd0, rd_dep_q});
  assign trial   = {dr_q[63:0], dq_q[63]};

  always_comb begin
    state_d = state_q;   ret_d = ret_q;     done_d = 1'b0;   clr_d = clr_q;
    act_d = act_q;       val_d = val_q;     cx_d = cx_q;     cy_d = cy_q;
    dir_d = dir_q;       area_d = area_q;   n_d = n_q;       sub_d = sub_q;
    subdt_d = subdt_q;   c_d = c_q;         factor_d = factor_q;
    r_d = r_q;           term_d = term_q;   sum_d = sum_q;   k_d = k_q;
    ecnt_d = ecnt_q;     v_d = v_q;         e_d = e_q;       d_d = d_q;
    f_d = f_q;           s_d = s_q;         allowed_d = allowed_q;
    neg_d = neg_q;       in_d = in_q;       out_d = out_q;   acc_d = acc_q;
    ma_d = ma_q;         mb_d = mb_q;       prod_d = prod_q; mcnt_d = mcnt_q;
    dq_d = dq_q;         dd_d = dd_q;       dr_d = dr_q;     dcnt_d = dcnt_q;
    status_d = status_q; wdep_d = wdep_q;   terr_d = terr_q; fo_d = fo_q;
    vol_d = vol_q;       nrun_d = nrun_q;
    we_terr = 1'b0;      we_dep = 1'b0;     we_flx = 1'b0;
    wd_terr = val_q;     wd_dep = '0;       wd_flx = f_q;
    mul_go = 1'b0;       div_go = 1'b0;     go_ret = S_IDLE;
    mul_a = '0;          mul_b = '0;        div_n = '0;      div_m = 64'd1;
    diff = '0;           mag = '0;          t64 = '0;        q64 = '0;
    x64 = '0;            nint = '0;         pp = '0;         pp_ext = '0;
    nd_u = '0;           nd_s = '0;         delta = '0;      sum_new = '0;
    acc_new = '0;        p63 = '0;

    unique case (state_q)
      S_CLEAR: begin
        we_terr = 1'b1;
        we_dep  = 1'b1;
        we_flx  = 1'b1;
        wd_terr = '0;
        wd_flx  = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          act_d = action_i;
          val_d = value_i;
          cx_d = {1'b0, cell_x_i};
          cy_d = {1'b0, cell_y_i};
          status_d = 1'b0; wdep_d = '0; terr_d = '0; fo_d = '0; vol_d = '0; nrun_d = '0;
          mul_go = 1'b1; mul_a = {33'd0, csz_q}; mul_b = {33'd0, csz_q}; go_ret = S_AREA;
        end
      end
      S_AREA: begin
        area_d = prod_q[F +: AREA_W];
        if (prod_q[F +: AREA_W] == '0) area_d = AREA_W'(1);
        unique case (act_q)
          swps_pkg::ACT_TERRAIN, swps_pkg::ACT_ADD, swps_pkg::ACT_REMOVE,
          swps_pkg::ACT_READ: begin
            if (bad) begin
              status_d = 1'b1; done_d = 1'b1; state_d = S_IDLE;
            end else if (act_q == swps_pkg::ACT_TERRAIN) begin
              we_terr = 1'b1; done_d = 1'b1; state_d = S_IDLE;
            end else begin
              state_d = S_RD;
            end
          end
          swps_pkg::ACT_STEP: begin
            if (!val_q[31] && val_q != 32'd0) begin
              div_go = 1'b1; div_n = {32'd0, val_q} + msd64 - 64'd1; div_m = msd64;
              go_ret = S_NDIV;
            end else begin
              done_d = 1'b1; state_d = S_IDLE;
            end
          end
          swps_pkg::ACT_VOLUME: begin
            cx_d = '0; cy_d = '0; acc_d = '0; state_d = S_VOL_RD;
          end
          default: begin
            done_d = 1'b1; state_d = S_IDLE;
          end
        endcase
      end
      S_RD: begin
        if (act_q == swps_pkg::ACT_READ) begin
          wdep_d = rd_dep_q; terr_d = rd_terr_q; fo_d = rd_flx_q;
          done_d = 1'b1; state_d = S_IDLE;
        end else begin
          d_d = rd_dep_q;
          neg_d = val_q[31] ^ (act_q == swps_pkg::ACT_REMOVE);
          div_go = 1'b1; div_n = vabs << F; div_m = 64'(area_q); go_ret = S_ADDDIV;
        end
      end
      S_ADDDIV: begin
        if (neg_q) nd_u = (dq_q >= {33'd0, d_q}) ? 64'd0 : {33'd0, d_q} - dq_q;
        else begin
          nd_u = {33'd0, d_q} + dq_q;
          if (nd_u > {33'd0, swps_pkg::VAL_MAX}) nd_u = {33'd0, swps_pkg::VAL_MAX};
        end
        wd_dep = nd_u[30:0]; we_dep = 1'b1; done_d = 1'b1; state_d = S_IDLE;
      end
      S_NDIV: begin
        n_d = (dq_q > 64'd65535) ? 16'hFFFF : dq_q[15:0];
        div_go = 1'b1; div_n = {32'd0, val_q};
        div_m = (dq_q > 64'd65535) ? 64'd65535 : dq_q;
        go_ret = S_SUBDIV;
      end
      S_SUBDIV: begin
        subdt_d = dq_q[30:0];
        sub_d = '0;
        if (damp_q != 31'd0) begin
          mul_go = 1'b1; mul_a = {33'd0, damp_q}; mul_b = dq_q; go_ret = S_XMUL;
        end else begin
          state_d = S_CSTART;
        end
      end
      S_XMUL: begin
        x64 = prod_q[63:0] >> F;
        nint = x64 >> F;
        if (nint >= 64'd32) begin
          factor_d = '0; state_d = S_CSTART;
        end else begin
          r_d = 30'(x64[F-1:0]) << (30 - F);
          term_d = swps_pkg::ONE_Q30[30:0];
          sum_d = $signed(swps_pkg::ONE_Q30[33:0]);
          k_d = 4'd1;
          ecnt_d = nint[4:0];
          mul_go = 1'b1; mul_a = swps_pkg::ONE_Q30;
          mul_b = {34'd0, 30'(x64[F-1:0]) << (30 - F)}; go_ret = S_TAYMUL;
        end
      end
      S_TAYMUL: begin
        div_go = 1'b1; div_n = prod_q[93:30]; div_m = {60'd0, k_q}; go_ret = S_TAYDIV;
      end
      S_TAYDIV: begin
        term_d = dq_q[30:0];
        sum_new = k_q[0] ? sum_q - $signed({3'd0, dq_q[30:0]})
                         : sum_q + $signed({3'd0, dq_q[30:0]});
        sum_d = sum_new;
        if (k_q == 4'd12) begin
          v_d = sum_new[33] ? 31'd0 : sum_new[30:0];
          state_d = S_EXPCHK;
        end else begin
          k_d = k_q + 4'd1;
          mul_go = 1'b1; mul_a = {33'd0, dq_q[30:0]}; mul_b = {34'd0, r_q}; go_ret = S_TAYMUL;
        end
      end
      S_EXPCHK: begin
        if (ecnt_q == 5'd0) begin
          factor_d = (F + 1)'(v_q >> (30 - F));
          state_d = S_CSTART;
        end else begin
          ecnt_d = ecnt_q - 5'd1;
          mul_go = 1'b1; mul_a = {33'd0, v_q}; mul_b = swps_pkg::EXP_M1_Q30; go_ret = S_EXPMUL;
        end
      end
      S_EXPMUL: begin
        v_d = prod_q[60:30];
        state_d = S_EXPCHK;
      end
      S_CSTART: begin
        mul_go = 1'b1; mul_a = {33'd0, subdt_q}; mul_b = {33'd0, grav_q}; go_ret = S_CMUL;
      end
      S_CMUL: begin
        div_go = 1'b1; div_n = prod_q[63:0]; div_m = dx64; go_ret = S_CDIV;
      end
      S_CDIV: begin
        c_d = dq_q; cx_d = '0; cy_d = '0; state_d = S_P1_RD;
      end
      S_P1_RD: state_d = S_P1_OWN;
      S_P1_OWN: begin
        e_d = nb_elev; d_d = rd_dep_q; f_d = rd_flx_q; dir_d = '0; state_d = S_P1_NB;
      end
      S_P1_NB: begin
        if (nb_ok) state_d = S_P1_DIFF;
        else begin
          f_d[dir_q] = '0;
          if (dir_q == 2'd3) state_d = S_P1_SUM;
          else dir_d = dir_q + 2'd1;
        end
      end
      S_P1_DIFF: begin
        diff = 35'(e_q) - 35'(nb_elev);
        mag = diff[34] ? 35'd0 - diff : diff;
        neg_d = diff[34];
        mul_go = 1'b1; mul_a = c_q; mul_b = {29'd0, mag}; go_ret = S_P1_PIPE;
      end
      S_P1_PIPE: begin
        t64 = sat62 >> F;
        if (neg_q) nd_u = (t64 >= {33'd0, f_q[dir_q]}) ? 64'd0 : {33'd0, f_q[dir_q]} - t64;
        else begin
          nd_u = {33'd0, f_q[dir_q]} + t64;
          if (nd_u > {33'd0, swps_pkg::VAL_MAX}) nd_u = {33'd0, swps_pkg::VAL_MAX};
        end
        f_d[dir_q] = nd_u[30:0];
        if (dir_q == 2'd3) state_d = S_P1_SUM;
        else begin
          dir_d = dir_q + 2'd1; state_d = S_P1_NB;
        end
      end
      S_P1_SUM: begin
        s_d = 33'(f_q[0]) + 33'(f_q[1]) + 33'(f_q[2]) + 33'(f_q[3]);
        if (33'(f_q[0]) + 33'(f_q[1]) + 33'(f_q[2]) + 33'(f_q[3]) == 33'd0) state_d = S_P1_WR;
        else begin
          mul_go = 1'b1; mul_a = {33'd0, d_q}; mul_b = 64'(area_q); go_ret = S_P1_AMUL;
        end
      end
      S_P1_AMUL: begin
        div_go = 1'b1; div_n = sat63; div_m = {33'd0, subdt_q}; go_ret = S_P1_ALW;
      end
      S_P1_ALW: begin
        allowed_d = dq_q[62:0];
        if (dq_q < {31'd0, s_q}) begin
          dir_d = '0;
          mul_go = 1'b1; mul_a = {33'd0, f_q[0]}; mul_b = dq_q; go_ret = S_P1_LMUL;
        end else state_d = S_P1_WR;
      end
      S_P1_LMUL: begin
        div_go = 1'b1; div_n = prod_q[63:0]; div_m = {31'd0, s_q}; go_ret = S_P1_LDIV;
      end
      S_P1_LDIV: begin
        f_d[dir_q] = dq_q[30:0];
        if (dir_q == 2'd3) state_d = S_P1_WR;
        else begin
          dir_d = dir_q + 2'd1;
          mul_go = 1'b1; mul_a = {33'd0, f_q[dir_q + 2'd1]}; mul_b = {1'b0, allowed_q};
          go_ret = S_P1_LMUL;
        end
      end
      S_P1_WR: begin
        we_flx = 1'b1;
        if (last_cell) begin
          cx_d = '0; cy_d = '0;
          state_d = (damp_q != 31'd0) ? S_P2_RD : S_P3_RD;
        end else begin
          cx_d = nx; cy_d = ny; state_d = S_P1_RD;
        end
      end
      S_P2_RD: state_d = S_P2_OWN;
      S_P2_OWN: begin
        f_d = rd_flx_q; dir_d = '0;
        mul_go = 1'b1; mul_a = {33'd0, rd_flx_q[0]}; mul_b = 64'(factor_q); go_ret = S_P2_MUL;
      end
      S_P2_MUL: begin
        f_d[dir_q] = prod_q[F +: 31];
        if (dir_q == 2'd3) state_d = S_P2_WR;
        else begin
          dir_d = dir_q + 2'd1;
          mul_go = 1'b1; mul_a = {33'd0, f_q[dir_q + 2'd1]}; mul_b = 64'(factor_q);
          go_ret = S_P2_MUL;
        end
      end
      S_P2_WR: begin
        we_flx = 1'b1;
        if (last_cell) begin
          cx_d = '0; cy_d = '0; state_d = S_P3_RD;
        end else begin
          cx_d = nx; cy_d = ny; state_d = S_P2_RD;
        end
      end
      S_P3_RD: state_d = S_P3_OWN;
      S_P3_OWN: begin
        d_d = rd_dep_q;
        out_d = 33'(rd_flx_q[0]) + 33'(rd_flx_q[1]) + 33'(rd_flx_q[2]) + 33'(rd_flx_q[3]);
        in_d = '0; dir_d = '0; state_d = S_P3_NB;
      end
      S_P3_NB: begin
        if (nb_ok) state_d = S_P3_ACC;
        else if (dir_q == 2'd3) state_d = S_P3_CALC;
        else dir_d = dir_q + 2'd1;
      end
      S_P3_ACC: begin
        unique case (dir_q)
          2'd0: in_d = in_q + 33'(rd_flx_q[1]);
          2'd1: in_d = in_q + 33'(rd_flx_q[0]);
          2'd2: in_d = in_q + 33'(rd_flx_q[3]);
          default: in_d = in_q + 33'(rd_flx_q[2]);
        endcase
        if (dir_q == 2'd3) state_d = S_P3_CALC;
        else begin
          dir_d = dir_q + 2'd1; state_d = S_P3_NB;
        end
      end
      S_P3_CALC: begin
        diff = $signed({2'd0, in_q}) - $signed({2'd0, out_q});
        mag = diff[34] ? 35'd0 - diff : diff;
        neg_d = diff[34];
        mul_go = 1'b1; mul_a = {29'd0, mag}; mul_b = {33'd0, subdt_q}; go_ret = S_P3_MUL;
      end
      S_P3_MUL: begin
        div_go = 1'b1; div_n = sat63; div_m = 64'(area_q); go_ret = S_P3_DIV;
      end
      S_P3_DIV: begin
        q64 = (dq_q > 64'h1_0000_0000) ? 64'h1_0000_0000 : dq_q;
        delta = q64[32:0];
        nd_s = neg_q ? $signed({4'd0, d_q}) - $signed({2'd0, delta})
                     : $signed({4'd0, d_q}) + $signed({2'd0, delta});
        if (nd_s < 35'sd0 || nd_s < 35'(TINY)) wd_dep = '0;
        else if (nd_s > $signed({4'd0, swps_pkg::VAL_MAX})) wd_dep = swps_pkg::VAL_MAX;
        else wd_dep = nd_s[30:0];
        we_dep = 1'b1;
        if (last_cell) begin
          cx_d = '0; cy_d = '0;
          if (sub_q + 16'd1 == n_q) begin
            nrun_d = n_q; done_d = 1'b1; state_d = S_IDLE;
          end else begin
            sub_d = sub_q + 16'd1; state_d = S_P1_RD;
          end
        end else begin
          cx_d = nx; cy_d = ny; state_d = S_P3_RD;
        end
      end
      S_VOL_RD: state_d = S_VOL_GO;
      S_VOL_GO: begin
        mul_go = 1'b1; mul_a = {33'd0, rd_dep_q}; mul_b = 64'(area_q); go_ret = S_VOL_ACC;
      end
      S_VOL_ACC: begin
        p63 = sat63;
        acc_new = (p63[62:0] > swps_pkg::LIM63[62:0] - acc_q) ? swps_pkg::LIM63[62:0]
                                                             : acc_q + p63[62:0];
        acc_d = acc_new;
        if (last_cell) begin
          vol_d = acc_new; done_d = 1'b1; state_d = S_IDLE;
        end else begin
          cx_d = nx; cy_d = ny; state_d = S_VOL_RD;
        end
      end
      S_MUL: begin
        unique case (mcnt_q)
          2'd0: begin
            pp = ma_q[31:0] * mb_q[31:0];  pp_ext = {64'd0, pp};
          end
          2'd1: begin
            pp = ma_q[63:32] * mb_q[31:0]; pp_ext = {32'd0, pp, 32'd0};
          end
          2'd2: begin
            pp = ma_q[31:0] * mb_q[63:32]; pp_ext = {32'd0, pp, 32'd0};
          end
          default: begin
            pp = ma_q[63:32] * mb_q[63:32]; pp_ext = {pp, 64'd0};
          end
        endcase
        prod_d = prod_q + pp_ext;
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd3) state_d = ret_q;
      end
      S_DIV: begin
        if (trial >= {1'b0, dd_q}) begin
          dr_d = trial - {1'b0, dd_q}; dq_d = {dq_q[62:0], 1'b1};
        end else begin
          dr_d = trial; dq_d = {dq_q[62:0], 1'b0};
        end
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) state_d = ret_q;
      end
      default: state_d = S_IDLE;
    endcase

    if (mul_go) begin
      ma_d = mul_a; mb_d = mul_b; prod_d = '0; mcnt_d = '0; ret_d = go_ret; state_d = S_MUL;
    end
    if (div_go) begin
      dq_d = div_n; dd_d = div_m; dr_d = '0; dcnt_d = '0; ret_d = go_ret; state_d = S_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_IDLE;
      done_q  <= 1'b0;
      clr_q   <= '0;
      gw_q    <= swps_pkg::WIDTH_RST;
      gh_q    <= swps_pkg::HEIGHT_RST;
      csz_q   <= swps_pkg::CELL_RST;
      grav_q  <= swps_pkg::GRAVITY_RST;
      msd_q   <= swps_pkg::SUBDT_RST;
      damp_q  <= swps_pkg::DAMPING_RST;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      done_q  <= done_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          swps_pkg::REG_WIDTH:   gw_q   <= cfg_wdata_i[6:0];
          swps_pkg::REG_HEIGHT:  gh_q   <= cfg_wdata_i[6:0];
          swps_pkg::REG_CELL:    csz_q  <= cfg_wdata_i;
          swps_pkg::REG_GRAVITY: grav_q <= cfg_wdata_i;
          swps_pkg::REG_SUBDT:   msd_q  <= cfg_wdata_i;
          swps_pkg::REG_DAMPING: damp_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;       val_q <= val_d;     cx_q <= cx_d;       cy_q <= cy_d;
    dir_q <= dir_d;       area_q <= area_d;   n_q <= n_d;         sub_q <= sub_d;
    subdt_q <= subdt_d;   c_q <= c_d;         factor_q <= factor_d;
    r_q <= r_d;           term_q <= term_d;   sum_q <= sum_d;     k_q <= k_d;
    ecnt_q <= ecnt_d;     v_q <= v_d;         e_q <= e_d;         d_q <= d_d;
    f_q <= f_d;           s_q <= s_d;         allowed_q <= allowed_d;
    neg_q <= neg_d;       in_q <= in_d;       out_q <= out_d;     acc_q <= acc_d;
    ma_q <= ma_d;         mb_q <= mb_d;       prod_q <= prod_d;   mcnt_q <= mcnt_d;
    dq_q <= dq_d;         dd_q <= dd_d;       dr_q <= dr_d;       dcnt_q <= dcnt_d;
    status_q <= status_d; wdep_q <= wdep_d;   terr_q <= terr_d;   fo_q <= fo_d;
    vol_q <= vol_d;       nrun_q <= nrun_d;
  end

  assign busy_o           = state_q != S_IDLE;
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign water_depth_o    = wdep_q;
  assign terrain_height_o = terr_q;
  assign flux_left_o      = fo_q[0];
  assign flux_right_o     = fo_q[1];
  assign flux_top_o       = fo_q[2];
  assign flux_bottom_o    = fo_q[3];
  assign total_volume_o   = vol_q;
  assign substeps_run_o   = nrun_q;

endmodule

// ===== rtl/swps_chk.sv =====
// swps_chk: port-level checker for shallow_water_pipe_step, bound into every instance of it
// depends on shallow_water_pipe_step port names
module swps_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        status_o,
  input logic [30:0] water_depth_o,
  input logic [62:0] total_volume_o,
  input logic [15:0] substeps_run_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobed while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted transaction did not start");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (total_volume_o == 63'd0 && substeps_run_o == 16'd0 &&
                              water_depth_o == 31'd0))
    else $error("error result carries data");

endmodule

bind shallow_water_pipe_step swps_chk u_swps_chk (.*);

// ===== tb/tb_shallow_water_pipe_step.sv =====
// tb_shallow_water_pipe_step: self-checking testbench of the shallow water pipe step block
// predicts every result from its own fixed-point grid model and checks it on done_o
// depends on rtl/swps_pkg.sv and rtl/shallow_water_pipe_step.sv
module tb_shallow_water_pipe_step;
  timeunit 1ns;
  timeprecision 1ps;
  import swps_pkg::*;

  localparam int NCOL = 64;
  localparam int NROW = 64;
  localparam int NCELL = NCOL * NROW;
  localparam longint unsigned CYCLE_LIMIT = 150_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [2:0] ACT_BAD6 = 3'd6;
  localparam logic [2:0] ACT_BAD7 = 3'd7;

  typedef struct {
    bit         status;
    bit [30:0]  depth;
    bit [31:0]  terrain;
    bit [30:0]  fl;
    bit [30:0]  fr;
    bit [30:0]  ft;
    bit [30:0]  fb;
    bit [62:0]  volume;
    bit [15:0]  substeps;
  } cell_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         action_i = '0;
  logic [5:0]         cell_x_i = '0;
  logic [5:0]         cell_y_i = '0;
  logic signed [31:0] value_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_addr_i = '0;
  logic [30:0]        cfg_wdata_i = '0;
  logic               done_o;
  logic               status_o;
  logic [30:0]        water_depth_o;
  logic signed [31:0] terrain_height_o;
  logic [30:0]        flux_left_o;
  logic [30:0]        flux_right_o;
  logic [30:0]        flux_top_o;
  logic [30:0]        flux_bottom_o;
  logic [62:0]        total_volume_o;
  logic [15:0]        substeps_run_o;

  shallow_water_pipe_step uut (.*);

  bit [6:0]  m_width, m_height;
  bit [30:0] m_cell, m_gravity, m_subdt, m_damping;
  bit [31:0] m_terrain [NCELL];
  bit [31:0] m_depth [NCELL];
  bit [31:0] m_left [NCELL];
  bit [31:0] m_right [NCELL];
  bit [31:0] m_top [NCELL];
  bit [31:0] m_bottom [NCELL];

  cell_result_t pending_results[$];
  int mismatches = 0;
  int unexpected = 0;
  bit no_idle = 0;
  longint unsigned cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit [63:0] sat_mul(bit [63:0] a, bit [63:0] b, bit [63:0] lim);
    bit [63:0] p;
    if (a != 0 && b > lim / a) return lim;
    p = a * b;
    return (p > lim) ? lim : p;
  endfunction

  function automatic bit [31:0] clamp_depth(longint v);
    if (v < 0) return 0;
    if (v > longint'(VAL_MAX)) return {1'b0, VAL_MAX};
    return v[31:0];
  endfunction

  function automatic int grid_cols();
    if (m_width == 0) return 1;
    return (m_width > NCOL) ? NCOL : m_width;
  endfunction

  function automatic int grid_rows();
    if (m_height == 0) return 1;
    return (m_height > NROW) ? NROW : m_height;
  endfunction

  function automatic bit [63:0] cell_area();
    bit [63:0] a;
    a = (64'(m_cell) * 64'(m_cell)) >> 16;
    return (a == 0) ? 64'd1 : a;
  endfunction

  function automatic bit [63:0] decay_factor(bit [63:0] x);
    bit [63:0] n, r, term, v;
    longint sum;
    n = x >> 16;
    r = (x & 64'hFFFF) << 14;
    term = ONE_Q30;
    sum = longint'(ONE_Q30);
    if (n >= 32) return 0;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * r) >> 30) / k;
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    v = (sum < 0) ? 64'd0 : 64'(sum);
    for (int i = 0; i < n; i++) v = (v * EXP_M1_Q30) >> 30;
    return v >> 14;
  endfunction

  function automatic longint surface(int i);
    return longint'($signed(m_terrain[i])) + longint'(m_depth[i]);
  endfunction

  function automatic bit [31:0] pipe_flux(bit [31:0] prev, bit [63:0] c, longint diff);
    bit [63:0] mag;
    longint t;
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    t = longint'(sat_mul(c, mag, LIM62) >> 16);
    return clamp_depth((diff < 0) ? longint'(prev) - t : longint'(prev) + t);
  endfunction

  task automatic run_substep(bit [63:0] subdt, bit damp, bit [63:0] factor);
    int w, h, i;
    bit [63:0] dx, a, c, s, allowed;
    longint e, outflow, inflow, diff, nd;
    bit [63:0] mag, delta;
    w = grid_cols();
    h = grid_rows();
    dx = (m_cell != 0) ? 64'(m_cell) : 64'd1;
    a = cell_area();
    c = (subdt * 64'(m_gravity)) / dx;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        i = y * NCOL + x;
        e = surface(i);
        m_left[i] = (x > 0) ? pipe_flux(m_left[i], c, e - surface(i - 1)) : 0;
        m_right[i] = (x + 1 < w) ? pipe_flux(m_right[i], c, e - surface(i + 1)) : 0;
        m_top[i] = (y > 0) ? pipe_flux(m_top[i], c, e - surface(i - NCOL)) : 0;
        m_bottom[i] = (y + 1 < h) ? pipe_flux(m_bottom[i], c, e - surface(i + NCOL)) : 0;
        s = 64'(m_left[i]) + 64'(m_right[i]) + 64'(m_top[i]) + 64'(m_bottom[i]);
        if (s != 0) begin
          allowed = sat_mul(64'(m_depth[i]), a, LIM63) / subdt;
          if (allowed < s) begin
            m_left[i] = 32'((64'(m_left[i]) * allowed) / s);
            m_right[i] = 32'((64'(m_right[i]) * allowed) / s);
            m_top[i] = 32'((64'(m_top[i]) * allowed) / s);
            m_bottom[i] = 32'((64'(m_bottom[i]) * allowed) / s);
          end
        end
      end
    end
    if (damp) begin
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          i = y * NCOL + x;
          m_left[i] = 32'((64'(m_left[i]) * factor) >> 16);
          m_right[i] = 32'((64'(m_right[i]) * factor) >> 16);
          m_top[i] = 32'((64'(m_top[i]) * factor) >> 16);
          m_bottom[i] = 32'((64'(m_bottom[i]) * factor) >> 16);
        end
      end
    end
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        i = y * NCOL + x;
        outflow = longint'(m_left[i]) + longint'(m_right[i]) + longint'(m_top[i])
                  + longint'(m_bottom[i]);
        inflow = 0;
        if (x > 0) inflow += longint'(m_right[i - 1]);
        if (x + 1 < w) inflow += longint'(m_left[i + 1]);
        if (y > 0) inflow += longint'(m_bottom[i - NCOL]);
        if (y + 1 < h) inflow += longint'(m_top[i + NCOL]);
        diff = inflow - outflow;
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        delta = sat_mul(mag, subdt, LIM63) / a;
        if (delta > 64'h1_0000_0000) delta = 64'h1_0000_0000;
        nd = (diff < 0) ? longint'(m_depth[i]) - longint'(delta)
                        : longint'(m_depth[i]) + longint'(delta);
        m_depth[i] = (nd < longint'(65536 / 1000000)) ? 32'd0 : clamp_depth(nd);
      end
    end
  endtask

  task automatic predict_grid(input logic [2:0] act, input int x, input int y,
                              input logic signed [31:0] val, output cell_result_t r);
    int i;
    bit bad;
    longint dv;
    bit [63:0] dt, msd, n, subdt, factor, acc, p, a;
    r = '{default: 0};
    bad = (x >= grid_cols()) || (y >= grid_rows());
    i = y * NCOL + x;
    case (act)
      ACT_TERRAIN, ACT_ADD, ACT_REMOVE, ACT_READ: begin
        if (bad) r.status = 1;
        else if (act == ACT_TERRAIN) m_terrain[i] = val;
        else if (act == ACT_READ) begin
          r.depth = m_depth[i][30:0];
          r.terrain = m_terrain[i];
          r.fl = m_left[i][30:0];
          r.fr = m_right[i][30:0];
          r.ft = m_top[i][30:0];
          r.fb = m_bottom[i][30:0];
        end else begin
          dv = (longint'(val) * 65536) / longint'(cell_area());
          if (act == ACT_REMOVE) dv = -dv;
          m_depth[i] = clamp_depth(longint'(m_depth[i]) + dv);
        end
      end
      ACT_STEP: begin
        if (val > 0) begin
          dt = 64'(val);
          msd = (m_subdt != 0) ? 64'(m_subdt) : 64'd1;
          n = (dt + msd - 1) / msd;
          if (n > 65535) n = 65535;
          subdt = dt / n;
          factor = 0;
          if (m_damping != 0) factor = decay_factor((64'(m_damping) * subdt) >> 16);
          for (bit [63:0] s = 0; s < n; s++) run_substep(subdt, m_damping != 0, factor);
          r.substeps = n[15:0];
        end
      end
      ACT_VOLUME: begin
        a = cell_area();
        acc = 0;
        for (int cy = 0; cy < grid_rows(); cy++) begin
          for (int cx = 0; cx < grid_cols(); cx++) begin
            p = sat_mul(64'(m_depth[cy * NCOL + cx]), a, LIM63);
            acc = (p > LIM63 - acc) ? LIM63 : acc + p;
          end
        end
        r.volume = acc[62:0];
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    cell_result_t e;
    bit bad;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10) $display("unexpected transaction at cycle %0d", cycles);
      end else begin
        e = pending_results.pop_front();
        bad = (status_o !== e.status) || (water_depth_o !== e.depth)
              || (terrain_height_o !== e.terrain) || (flux_left_o !== e.fl)
              || (flux_right_o !== e.fr) || (flux_top_o !== e.ft)
              || (flux_bottom_o !== e.fb) || (total_volume_o !== e.volume)
              || (substeps_run_o !== e.substeps);
        if (bad) begin
          mismatches++;
          if (mismatches + unexpected <= 10) begin
            $display("mismatch exp st=%0d d=%0d t=%0d f=%0d/%0d/%0d/%0d v=%0d n=%0d",
                     e.status, e.depth, $signed(e.terrain), e.fl, e.fr, e.ft, e.fb,
                     e.volume, e.substeps);
            $display("         act st=%0d d=%0d t=%0d f=%0d/%0d/%0d/%0d v=%0d n=%0d",
                     status_o, water_depth_o, terrain_height_o, flux_left_o, flux_right_o,
                     flux_top_o, flux_bottom_o, total_volume_o, substeps_run_o);
          end
        end
      end
    end
  end

  task automatic send_item(logic [2:0] act, int x, int y, logic signed [31:0] val);
    cell_result_t r;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    start_i = 1'b1;
    action_i = act;
    cell_x_i = x[5:0];
    cell_y_i = y[5:0];
    value_i = val;
    do @(posedge clk_i); while (busy_o);
    predict_grid(act, x, y, val, r);
    pending_results.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, bit [30:0] data);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_WIDTH:   m_width = data[6:0];
      REG_HEIGHT:  m_height = data[6:0];
      REG_CELL:    m_cell = data;
      REG_GRAVITY: m_gravity = data;
      REG_SUBDT:   m_subdt = data;
      REG_DAMPING: m_damping = data;
      default: ;
    endcase
  endtask

  task automatic configure(bit [6:0] w, bit [6:0] h, bit [30:0] cs, bit [30:0] g,
                           bit [30:0] sd, bit [30:0] dmp);
    drain();
    write_reg(REG_WIDTH, 31'(w));
    write_reg(REG_HEIGHT, 31'(h));
    write_reg(REG_CELL, cs);
    write_reg(REG_GRAVITY, g);
    write_reg(REG_SUBDT, sd);
    write_reg(REG_DAMPING, dmp);
  endtask

  task automatic test_reset_state();
    send_item(ACT_READ, 0, 0, 0);
    send_item(ACT_READ, 63, 63, 0);
    send_item(ACT_VOLUME, 0, 0, 0);
  endtask

  task automatic test_cell_writes();
    configure(7'd64, 7'd1, 31'd65536, GRAVITY_RST, SUBDT_RST, 31'd0);
    send_item(ACT_TERRAIN, 63, 0, 32'sh8000_0000);
    send_item(ACT_TERRAIN, 1, 0, 32'sh7FFF_FFFF);
    send_item(ACT_ADD, 63, 0, 32'sh7FFF_FFFF);
    send_item(ACT_ADD, 63, 0, 32'sh7FFF_FFFF);
    send_item(ACT_REMOVE, 1, 0, 32'sh7FFF_FFFF);
    send_item(ACT_ADD, 2, 0, 32'sh8000_0000);
    send_item(ACT_READ, 63, 0, 0);
    send_item(ACT_READ, 1, 0, 0);
    send_item(ACT_READ, 5, 1, 0);
    send_item(ACT_ADD, 0, 63, 100);
    send_item(ACT_BAD6, 3, 0, 32'sh1234_5678);
    send_item(ACT_BAD7, 63, 63, -1);
    send_item(ACT_VOLUME, 0, 0, 0);
  endtask

  task automatic test_bad_geometry();
    configure(7'd0, 7'd127, 31'd0, 31'h7FFF_FFFF, 31'd0, 31'd0);
    send_item(ACT_ADD, 0, 5, 32'sd3);
    send_item(ACT_READ, 1, 0, 0);
    send_item(ACT_STEP, 0, 0, 32'sd2);
    send_item(ACT_READ, 0, 5, 0);
    configure(7'd1, 7'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(ACT_ADD, 0, 0, 32'sh7FFF_FFFF);
    send_item(ACT_STEP, 0, 0, 32'sh7FFF_FFFF);
    send_item(ACT_VOLUME, 0, 0, 0);
  endtask

  task automatic test_flow_steps();
    configure(7'd3, 7'd3, 31'd65536, GRAVITY_RST, SUBDT_RST, 31'd0);
    send_item(ACT_TERRAIN, 0, 0, 32'sd65536);
    send_item(ACT_ADD, 1, 1, 32'sd655360);
    send_item(ACT_ADD, 0, 0, 32'sd65536);
    send_item(ACT_STEP, 0, 0, 32'sd0);
    send_item(ACT_STEP, 0, 0, -32'sd5);
    send_item(ACT_STEP, 0, 0, 32'sd3000);
    send_item(ACT_READ, 1, 1, 0);
    send_item(ACT_READ, 0, 1, 0);
    configure(7'd3, 7'd3, 31'd65536, GRAVITY_RST, SUBDT_RST, 31'd300000);
    send_item(ACT_STEP, 0, 0, 32'sd1049);
    send_item(ACT_READ, 1, 0, 0);
    send_item(ACT_VOLUME, 0, 0, 0);
  endtask

  task automatic test_substep_saturation();
    configure(7'd1, 7'd1, 31'd65536, GRAVITY_RST, 31'd0, 31'd0);
    send_item(ACT_STEP, 0, 0, 32'sd70000);
  endtask

  task automatic test_random_traffic();
    int w, h, x, y, pick;
    logic [2:0] act;
    logic signed [31:0] val;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) no_idle = 1;
      configure(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)),
                ($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'($urandom_range(16384, 262144)),
                ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 21)),
                31'($urandom_range(300, 5000)),
                ($urandom_range(0, 1) == 0) ? 31'd0 : 31'($urandom_range(1, 1 << 22)));
      w = grid_cols();
      h = grid_rows();
      for (int k = 0; k < 20; k++) begin
        pick = $urandom_range(0, 99);
        x = $urandom_range(0, w - 1);
        y = $urandom_range(0, h - 1);
        if ($urandom_range(0, 9) == 0) begin
          x = $urandom_range(0, 63);
          y = $urandom_range(0, 63);
        end
        val = ($urandom_range(0, 4) == 0) ? $urandom : $signed($urandom_range(0, 1 << 22));
        if (pick < 15) act = ACT_TERRAIN;
        else if (pick < 40) act = ACT_ADD;
        else if (pick < 50) act = ACT_REMOVE;
        else if (pick < 70) begin
          act = ACT_STEP;
          val = ($urandom_range(0, 7) == 0) ? -$signed($urandom_range(0, 1000))
                                            : $signed($urandom_range(1, 3 * int'(m_subdt)));
        end else if (pick < 95) act = ACT_READ;
        else if (pick < 98) act = ACT_VOLUME;
        else act = 3'($urandom_range(6, 7));
        send_item(act, x, y, val);
      end
    end
  endtask

  initial begin
    m_width = WIDTH_RST;
    m_height = HEIGHT_RST;
    m_cell = CELL_RST;
    m_gravity = GRAVITY_RST;
    m_subdt = SUBDT_RST;
    m_damping = DAMPING_RST;
    for (int i = 0; i < NCELL; i++) begin
      m_terrain[i] = 0;
      m_depth[i] = 0;
      m_left[i] = 0;
      m_right[i] = 0;
      m_top[i] = 0;
      m_bottom[i] = 0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_cell_writes();
    test_bad_geometry();
    test_flow_steps();
    test_substep_saturation();
    test_random_traffic();
    drain();
    if (mismatches == 0 && unexpected == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
